>>> design/assert_macros.svh
// Assertion macros for the design files.
// No dependencies; included by the top level where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every edge out of reset.
`define SSEM_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define SSEM_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSEM_ASSERT(name, clk, rstn, prop, msg)
`define SSEM_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

>>> design/ssem_pkg.sv
// Package for the SSEM processor step block: store geometry, request and result types,
// command and function codes, and the controller state type. No dependencies.
package ssem_pkg;

    // Store geometry; the line count is a power of two.
    localparam int STORE_LINES = 32;
    localparam int ADDR_W      = $clog2(STORE_LINES);
    localparam int WORD_W      = 32;
    localparam int FUNC_LSB    = 13;

    // Request commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    // Instruction functions.
    localparam logic [2:0] FN_JMP     = 3'd0;
    localparam logic [2:0] FN_JRP     = 3'd1;
    localparam logic [2:0] FN_LDN     = 3'd2;
    localparam logic [2:0] FN_STO     = 3'd3;
    localparam logic [2:0] FN_SUB     = 3'd4;
    localparam logic [2:0] FN_SUB_ALT = 3'd5;
    localparam logic [2:0] FN_CMP     = 3'd6;
    localparam logic [2:0] FN_STP     = 3'd7;
    localparam logic [2:0] FN_NONE    = 3'd0;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [4:0]        line;
        logic [WORD_W-1:0] word;
    } ssem_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]        ci;
        logic signed [WORD_W-1:0] acc;
        logic [WORD_W-1:0]        read_word;
        logic [2:0]               function_done;
        logic                     halted;
    } ssem_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_FETCH,
        ST_OPER,
        ST_FINISH
    } ssem_state_t;

endpackage

>>> design/ssem_processor_step.sv
// SSEM processor step: one request at a time against a single-port store.
// Flow: a write goes straight to result load; a read waits for the store read data; a
// step does fetch read, operand read with optional write-back, then result load (a halted
// machine goes straight to result load). The next request is taken the cycle after the
// result is loaded, later while the output register still holds a result not yet taken.
// Synchronous active-low reset clears CI, accumulator, halt and line valid bits (store reads 0).
`include "assert_macros.svh"

module ssem_processor_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ssem_pkg::ssem_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ssem_pkg::ssem_out_t m_data
);
    import ssem_pkg::*;

    // Architectural state and controller.
    ssem_state_t              state_reg, state_next;
    logic [WORD_W-1:0]        ci_reg, ci_next;
    logic signed [WORD_W-1:0] acc_reg, acc_next;
    logic                     halted_reg, halted_next;
    logic [WORD_W-1:0]        rd_reg, rd_next;
    logic [2:0]               fdone_reg, fdone_next;
    logic                     m_valid_reg, m_valid_next;
    ssem_out_t                m_data_reg;
    logic                     out_load;

    // Store and its single port.
    logic [WORD_W-1:0]        store_mem [STORE_LINES];
    logic [STORE_LINES-1:0]   line_valid_reg;
    logic [WORD_W-1:0]        mem_q_reg;
    logic                     valid_q_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_addr;
    logic [WORD_W-1:0]        mem_wdata;
    logic [WORD_W-1:0]        rdata;

    logic [WORD_W-1:0]        ci_inc;
    logic [2:0]               instr_func;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A line never written since reset reads as zero.
    assign rdata      = valid_q_reg ? mem_q_reg : '0;
    assign ci_inc     = ci_reg + WORD_W'(1);
    assign instr_func = rd_reg[FUNC_LSB +: 3];

    // Store array with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_addr] <= mem_wdata;
        end
        mem_q_reg   <= store_mem[mem_addr];
        valid_q_reg <= line_valid_reg[mem_addr];
    end

    // Per-line valid bits stand in for clearing the store at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_valid_reg <= '0;
        end else if (mem_we) begin
            line_valid_reg[mem_addr] <= 1'b1;
        end
    end

    // Controller and architectural registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ci_reg      <= '0;
            acc_reg     <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ci_reg      <= ci_next;
            acc_reg     <= acc_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Per-request payload registers.
    always_ff @(posedge aclk) begin
        rd_reg    <= rd_next;
        fdone_reg <= fdone_next;
        if (out_load) begin
            m_data_reg <= '{ci: ci_reg, acc: acc_reg, read_word: rd_reg,
                            function_done: fdone_reg, halted: halted_reg};
        end
    end

    // Next state, memory port control and instruction execution.
    always_comb begin
        state_next  = state_reg;
        ci_next     = ci_reg;
        acc_next    = acc_reg;
        halted_next = halted_reg;
        rd_next     = rd_reg;
        fdone_next  = fdone_reg;
        mem_we      = 1'b0;
        mem_addr    = '0;
        mem_wdata   = acc_reg;
        out_load    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rd_next    = '0;
                    fdone_next = FN_NONE;
                    state_next = ST_FINISH;
                    unique case (s_data.cmd)
                        CMD_WRITE: begin
                            mem_we    = 1'b1;
                            mem_addr  = ADDR_W'(s_data.line);
                            mem_wdata = s_data.word;
                        end
                        CMD_READ: begin
                            mem_addr   = ADDR_W'(s_data.line);
                            state_next = ST_READ_WAIT;
                        end
                        CMD_STEP: begin
                            // A halted machine does not execute a step; the request still returns a result.
                            if (!halted_reg) begin
                                ci_next    = ci_inc;
                                mem_addr   = ci_inc[ADDR_W-1:0];
                                state_next = ST_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ_WAIT: begin
                rd_next    = rdata;
                state_next = ST_FINISH;
            end
            ST_FETCH: begin
                // Instruction word arrives; issue the operand read.
                rd_next    = rdata;
                mem_addr   = rdata[ADDR_W-1:0];
                state_next = ST_OPER;
            end
            ST_OPER: begin
                fdone_next = instr_func;
                mem_addr   = rd_reg[ADDR_W-1:0];
                state_next = ST_FINISH;
                unique case (instr_func) inside
                    FN_JMP: ci_next = rdata;
                    FN_JRP: ci_next = ci_reg + rdata;
                    FN_LDN: acc_next = '0 - $signed(rdata);
                    FN_STO: begin
                        mem_we    = 1'b1;
                        mem_wdata = acc_reg;
                    end
                    FN_SUB, FN_SUB_ALT: acc_next = acc_reg - $signed(rdata);
                    FN_CMP: begin
                        if (acc_reg[WORD_W-1]) begin
                            ci_next = ci_inc;
                        end
                    end
                    FN_STP: halted_next = 1'b1;
                    default: begin
                    end
                endcase
            end
            ST_FINISH: begin
                // Load the result once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid_next = out_load | (m_valid_reg & ~m_ready);

    // Assertions.
    `SSEM_ASSERT(a_one_request, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second request taken while busy")
    `SSEM_ASSERT(a_halt_sticky, aclk, aresetn, halted_reg |=> halted_reg, "halt flag cleared without reset")
    `SSEM_ASSERT(a_write_slot, aclk, aresetn, mem_we |-> (state_reg == ST_IDLE || state_reg == ST_OPER), "store written outside a write slot")
    `SSEM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready, "result or busy state survives reset")

endmodule
